// ===== hw/rtl/satc_pkg.sv =====
// shared types and constants of the cache tag controller
package satc_pkg;

	localparam int ADDR_W = 64;
	localparam int LINE_SHIFT = 6;
	localparam int TAG_W = ADDR_W - LINE_SHIFT;
	localparam int OFF_W = LINE_SHIFT;
	localparam int WAY_W = 2;

	// classified access word passed from front to back
	typedef struct packed {
		logic             func;
		logic [TAG_W-1:0] tag;
		logic [OFF_W-1:0] offset;
	} req_t;

	// lookup result word
	typedef struct packed {
		logic              hit;
		logic [WAY_W-1:0]  way;
		logic [OFF_W-1:0]  line_offset;
		logic              writeback;
		logic [ADDR_W-1:0] writeback_address;
		logic [ADDR_W-1:0] fill_address;
	} res_t;

endpackage

// ===== hw/rtl/satc_front.sv =====
// front end: splits the access word and queues it for the back end
module satc_front import satc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              acc_valid,
	output logic              acc_ready,
	input  logic              func,
	input  logic [ADDR_W-1:0] address,
	output logic              req_valid,
	input  logic              req_ready,
	output req_t              req
);

	req_t       fifo_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;

	assign acc_ready = (count_q != 2'd2);
	assign req_valid = (count_q != 2'd0);
	assign push = acc_valid && acc_ready;
	assign pop = req_valid && req_ready;
	assign req = fifo_q[rd_ptr_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= '{func: func,
				tag: address[ADDR_W-1:LINE_SHIFT],
				offset: address[OFF_W-1:0]};
		end
	end

	// queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			case ({push, pop})
				2'b10: count_q <= count_q + 2'd1;
				2'b01: count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3) else $error("queue count out of range");
	a_full_no_push: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == 2'd2 |-> !push) else $error("push into full queue");
	a_ptr_match: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == 2'd0 || count_q == 2'd2) |-> wr_ptr_q == rd_ptr_q)
		else $error("queue pointers out of step");

endmodule

// ===== hw/rtl/satc_back.sv =====
// back end: set lookup, victim choice and tag, valid, dirty and lru update
module satc_back import satc_pkg::*; #(
	parameter int SET_COUNT = 64,
	parameter int WAY_COUNT = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic res_valid,
	input  logic res_ready,
	output res_t res
);

	localparam int SET_W = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 1;
	localparam int RW = (WAY_COUNT > 1) ? $clog2(WAY_COUNT) : 1;

	typedef enum logic [2:0] {
		ST_CLEAR = 3'b001,
		ST_IDLE  = 3'b010,
		ST_LOOK  = 3'b100
	} state_t;

	function automatic logic [SET_W-1:0] set_of(input logic [TAG_W-1:0] t);
		if (SET_COUNT > 1) return t[SET_W-1:0];
		return '0;
	endfunction

	// set rows
	logic [WAY_COUNT-1:0][TAG_W-1:0] tag_mem   [SET_COUNT];
	logic [WAY_COUNT-1:0]            valid_mem [SET_COUNT];
	logic [WAY_COUNT-1:0]            dirty_mem [SET_COUNT];
	logic [WAY_COUNT-1:0][RW-1:0]    rank_mem  [SET_COUNT];

	logic [WAY_COUNT-1:0][TAG_W-1:0] tag_rd_s1;
	logic [WAY_COUNT-1:0]            valid_rd_s1;
	logic [WAY_COUNT-1:0]            dirty_rd_s1;
	logic [WAY_COUNT-1:0][RW-1:0]    rank_rd_s1;

	state_t           state_q;
	logic [SET_W-1:0] clr_q;
	req_t             work_q;

	logic                            rd_en;
	logic                            upd_en;
	logic [SET_W-1:0]                work_set;
	logic [WAY_COUNT-1:0]            hit_vec;
	logic                            any_hit;
	logic                            any_inv;
	logic [RW-1:0]                   hit_way;
	logic [RW-1:0]                   inv_way;
	logic [RW-1:0]                   lru_way;
	logic [RW-1:0]                   sel;
	logic [RW-1:0]                   old_rank;
	logic [WAY_COUNT-1:0][TAG_W-1:0] tag_new;
	logic [WAY_COUNT-1:0]            valid_new;
	logic [WAY_COUNT-1:0]            dirty_new;
	logic [WAY_COUNT-1:0][RW-1:0]    rank_new;
	logic [WAY_COUNT-1:0][RW-1:0]    rank_init;
	logic                            wb;

	assign work_set = set_of(work_q.tag);
	assign rd_en = (state_q == ST_IDLE) && req_valid;
	assign req_ready = rd_en;
	assign res_valid = (state_q == ST_LOOK);
	assign upd_en = res_valid && res_ready;

	// reset row of the lru ranks
	always_comb begin
		for (int w = 0; w < WAY_COUNT; w++) rank_init[w] = RW'(w);
	end

	// hit detect and victim search
	always_comb begin
		hit_way = '0;
		inv_way = '0;
		lru_way = '0;
		any_inv = 1'b0;
		for (int w = WAY_COUNT - 1; w >= 0; w--) begin
			hit_vec[w] = valid_rd_s1[w] && (tag_rd_s1[w] == work_q.tag);
			if (hit_vec[w]) hit_way = RW'(w);
			if (!valid_rd_s1[w]) begin
				inv_way = RW'(w);
				any_inv = 1'b1;
			end
			if (rank_rd_s1[w] == RW'(WAY_COUNT - 1)) lru_way = RW'(w);
		end
		any_hit = |hit_vec;
		sel = any_hit ? hit_way : (any_inv ? inv_way : lru_way);
		old_rank = rank_rd_s1[sel];
	end

	// updated set row
	always_comb begin
		tag_new = tag_rd_s1;
		valid_new = valid_rd_s1;
		dirty_new = dirty_rd_s1;
		for (int w = 0; w < WAY_COUNT; w++) begin
			if (RW'(w) == sel) rank_new[w] = '0;
			else if (rank_rd_s1[w] < old_rank) rank_new[w] = rank_rd_s1[w] + RW'(1);
			else rank_new[w] = rank_rd_s1[w];
		end
		valid_new[sel] = 1'b1;
		if (any_hit) begin
			dirty_new[sel] = dirty_rd_s1[sel] | work_q.func;
		end else begin
			dirty_new[sel] = work_q.func;
			tag_new[sel] = work_q.tag;
		end
	end

	// result word
	always_comb begin
		wb = !any_hit && valid_rd_s1[sel] && dirty_rd_s1[sel];
		res.hit = any_hit;
		res.way = WAY_W'(sel);
		res.line_offset = work_q.offset;
		res.writeback = wb;
		res.writeback_address = wb ? {tag_rd_s1[sel], {LINE_SHIFT{1'b0}}} : '0;
		res.fill_address = any_hit ? '0 : {work_q.tag, {LINE_SHIFT{1'b0}}};
	end

	// set row memories
	always_ff @(posedge clk) begin
		if (rd_en) begin
			tag_rd_s1 <= tag_mem[set_of(req.tag)];
			valid_rd_s1 <= valid_mem[set_of(req.tag)];
			dirty_rd_s1 <= dirty_mem[set_of(req.tag)];
			rank_rd_s1 <= rank_mem[set_of(req.tag)];
		end
		if (state_q == ST_CLEAR) begin
			valid_mem[clr_q] <= '0;
			dirty_mem[clr_q] <= '0;
			rank_mem[clr_q] <= rank_init;
		end else if (upd_en) begin
			tag_mem[work_set] <= tag_new;
			valid_mem[work_set] <= valid_new;
			dirty_mem[work_set] <= dirty_new;
			rank_mem[work_set] <= rank_new;
		end
	end

	// held access word
	always_ff @(posedge clk) begin
		if (rd_en) work_q <= req;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + SET_W'(1);
					if (clr_q == SET_W'(SET_COUNT - 1)) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (rd_en) state_q <= ST_LOOK;
				end
				ST_LOOK: begin
					if (res_ready) state_q <= ST_IDLE;
				end
				default: state_q <= ST_CLEAR;
			endcase
		end
	end

	a_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(hit_vec) || state_q != ST_LOOK) else $error("multiple ways hit");
	a_wb_miss: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.writeback |-> !res.hit) else $error("writeback on hit");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(work_q))
		else $error("result dropped while stalled");

endmodule

// ===== hw/rtl/set_assoc_cache_tag_controller.sv =====
// A word accepted into the front queue passes the set row read registers of the back end
// and then the output word register before its result shows. The back end takes a new word
// only once it has read and then updated the set row of the last one in the single-port tag and state memories.
// Reset: arst_n clears control state; a clearing pass over all SET_COUNT sets
// then resets valid, dirty and lru rows, while up to two words may queue.
module set_assoc_cache_tag_controller import satc_pkg::*; #(
	parameter int SET_COUNT = 64,
	parameter int WAY_COUNT = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              acc_valid,
	output logic              acc_ready,
	input  logic              func,
	input  logic [ADDR_W-1:0] address,
	output logic              res_valid,
	input  logic              res_ready,
	output logic              hit,
	output logic [WAY_W-1:0]  way,
	output logic [OFF_W-1:0]  line_offset,
	output logic              writeback,
	output logic [ADDR_W-1:0] writeback_address,
	output logic [ADDR_W-1:0] fill_address
);

	req_t req;
	logic req_valid;
	logic req_ready;
	res_t back_res;
	logic back_valid;
	logic back_ready;
	res_t out_q;
	logic out_valid_q;

	satc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.acc_valid (acc_valid),
		.acc_ready (acc_ready),
		.func      (func),
		.address   (address),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req)
	);

	satc_back #(
		.SET_COUNT (SET_COUNT),
		.WAY_COUNT (WAY_COUNT)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.res_valid (back_valid),
		.res_ready (back_ready),
		.res       (back_res)
	);

	// output word register
	assign back_ready = !out_valid_q || res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (back_ready) begin
			out_valid_q <= back_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (back_ready && back_valid) out_q <= back_res;
	end

	assign res_valid = out_valid_q;
	assign hit = out_q.hit;
	assign way = out_q.way;
	assign line_offset = out_q.line_offset;
	assign writeback = out_q.writeback;
	assign writeback_address = out_q.writeback_address;
	assign fill_address = out_q.fill_address;

endmodule
